FILE: src/mtf_zero_run_decoder_top_assert.svh
// assertion macros for the mtf zero-run decoder
`ifndef MTF_ZERO_RUN_DECODER_TOP_ASSERT_SVH
`define MTF_ZERO_RUN_DECODER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MZR_ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mzr check failed");

// next-cycle implication, disabled in reset
`define MZR_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mzr check failed");

`endif

FILE: src/mzr_pkg.sv
package mzr_pkg;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;

	localparam logic [1:0] KIND_RUN = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_RUN_OVF  = 3'd1;
	localparam logic [2:0] ERR_BLK_OVF  = 3'd2;
	localparam logic [2:0] ERR_RANGE    = 3'd3;
	localparam logic [2:0] ERR_NO_BLOCK = 3'd4;

	localparam logic [3:0] LEVEL_RESET = 4'd9;
	localparam int unsigned BLOCK_UNIT = 100000;

	typedef enum logic [1:0] {
		RES_RUN,
		RES_END,
		RES_LIT,
		RES_ERR
	} res_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_J,
		RD_PREV
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_EMIT_RUN,
		S_SYM,
		S_READ_J,
		S_LOAD_B,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_LIT,
		S_EMIT_FINAL
	} state_t;

	typedef struct packed {
		logic     accept;
		logic     run_upd;
		logic     emit;
		res_sel_t emit_sel;
		logic [2:0] emit_code;
		logic     emit_last;
		rd_sel_t  rd_sel;
		logic     cap_b;
		logic     shift_wr;
		logic     front_wr;
	} cmd_t;

	typedef struct packed {
		logic       held_nz;
		logic [2:0] held_code;
		logic       open;
		logic       count_zero;
		logic       is_run;
		logic       run_pending;
		logic       run_over;
		logic       flush_over;
		logic       is_end;
		logic       out_of_range;
		logic       lit_over;
		logic       idx_zero;
		logic       slot_free;
	} stat_t;

	// largest block in bytes for a level, out-of-range levels clamped
	function automatic logic [19:0] level_limit(input logic [3:0] lv);
		logic [19:0] r;
		case (lv)
			4'd0, 4'd1: r = 20'(BLOCK_UNIT * 1);
			4'd2: r = 20'(BLOCK_UNIT * 2);
			4'd3: r = 20'(BLOCK_UNIT * 3);
			4'd4: r = 20'(BLOCK_UNIT * 4);
			4'd5: r = 20'(BLOCK_UNIT * 5);
			4'd6: r = 20'(BLOCK_UNIT * 6);
			4'd7: r = 20'(BLOCK_UNIT * 7);
			4'd8: r = 20'(BLOCK_UNIT * 8);
			default: r = 20'(BLOCK_UNIT * 9);
		endcase
		return r;
	endfunction

endpackage

FILE: src/mzr_ctrl.sv
module mzr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        op,
	output logic              in_ready,
	input  mzr_pkg::stat_t    stat,
	output mzr_pkg::cmd_t     cmd
);

	mzr_pkg::state_t   state_q, state_d;
	mzr_pkg::res_sel_t final_sel_q, final_sel_d;
	logic [2:0]        final_code_q, final_code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mzr_pkg::S_IDLE;
			final_sel_q  <= mzr_pkg::RES_END;
			final_code_q <= mzr_pkg::ERR_NONE;
		end else begin
			state_q      <= state_d;
			final_sel_q  <= final_sel_d;
			final_code_q <= final_code_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		final_sel_d   = final_sel_q;
		final_code_d  = final_code_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.emit_sel  = mzr_pkg::RES_END;
		cmd.rd_sel    = mzr_pkg::RD_NONE;
		case (state_q)
			mzr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (op == mzr_pkg::OP_DECODE) begin
						state_d = mzr_pkg::S_DECIDE;
					end
				end
			end
			mzr_pkg::S_DECIDE: begin
				state_d = mzr_pkg::S_EMIT_FINAL;
				final_sel_d = mzr_pkg::RES_ERR;
				if (stat.held_nz) begin
					final_code_d = stat.held_code;
				end else if (!stat.open) begin
					final_code_d = mzr_pkg::ERR_NO_BLOCK;
				end else if (stat.count_zero) begin
					final_code_d = mzr_pkg::ERR_RANGE;
				end else if (stat.is_run) begin
					cmd.run_upd = 1'b1;
					final_code_d = mzr_pkg::ERR_RUN_OVF;
					if (!stat.run_over) begin
						state_d = mzr_pkg::S_IDLE;
					end
				end else if (stat.run_pending) begin
					final_code_d = mzr_pkg::ERR_BLK_OVF;
					if (!stat.flush_over) begin
						state_d = mzr_pkg::S_EMIT_RUN;
					end
				end else begin
					state_d = mzr_pkg::S_SYM;
				end
			end
			mzr_pkg::S_EMIT_RUN: begin
				if (stat.slot_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = mzr_pkg::RES_RUN;
					state_d      = mzr_pkg::S_SYM;
				end
			end
			mzr_pkg::S_SYM: begin
				state_d = mzr_pkg::S_EMIT_FINAL;
				if (stat.is_end) begin
					final_sel_d  = mzr_pkg::RES_END;
					final_code_d = mzr_pkg::ERR_NONE;
				end else if (stat.out_of_range) begin
					final_sel_d  = mzr_pkg::RES_ERR;
					final_code_d = mzr_pkg::ERR_RANGE;
				end else begin
					state_d = mzr_pkg::S_READ_J;
				end
			end
			mzr_pkg::S_READ_J: begin
				cmd.rd_sel = mzr_pkg::RD_J;
				state_d    = mzr_pkg::S_LOAD_B;
			end
			mzr_pkg::S_LOAD_B: begin
				cmd.cap_b = 1'b1;
				state_d   = mzr_pkg::S_SHIFT_RD;
			end
			mzr_pkg::S_SHIFT_RD: begin
				if (stat.idx_zero) begin
					cmd.front_wr = 1'b1;
					state_d      = mzr_pkg::S_LIT;
				end else begin
					cmd.rd_sel = mzr_pkg::RD_PREV;
					state_d    = mzr_pkg::S_SHIFT_WR;
				end
			end
			mzr_pkg::S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = mzr_pkg::S_SHIFT_RD;
			end
			mzr_pkg::S_LIT: begin
				state_d = mzr_pkg::S_EMIT_FINAL;
				if (stat.lit_over) begin
					final_sel_d  = mzr_pkg::RES_ERR;
					final_code_d = mzr_pkg::ERR_BLK_OVF;
				end else begin
					final_sel_d  = mzr_pkg::RES_LIT;
					final_code_d = mzr_pkg::ERR_NONE;
				end
			end
			mzr_pkg::S_EMIT_FINAL: begin
				if (stat.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = final_sel_q;
					cmd.emit_code = final_code_q;
					cmd.emit_last = 1'b1;
					state_d       = mzr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mzr_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: src/mzr_datapath.sv
module mzr_datapath #(
	parameter int ALPHABET_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_wdata,
	input  logic [1:0]     op,
	input  logic [7:0]     in_byte,
	input  logic [8:0]     symbol,
	input  mzr_pkg::cmd_t  cmd,
	output mzr_pkg::stat_t stat,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     kind,
	output logic [7:0]     out_byte,
	output logic [19:0]    repeat_res,
	output logic [2:0]     error_code,
	output logic           last
);

	localparam int AW = $clog2(ALPHABET_DEPTH);
	localparam int CW = $clog2(ALPHABET_DEPTH + 1);

	logic [3:0]    level_q;
	logic [CW-1:0] count_q;
	logic [21:0]   weight_q, len_q;
	logic [19:0]   fill_q;
	logic          open_q;
	logic [2:0]    held_q;
	logic [8:0]    sym_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    b_q, front_q, rdata_q;
	logic [7:0]    mem [ALPHABET_DEPTH];

	logic          out_valid_q, last_q;
	logic [1:0]    kind_q;
	logic [7:0]    byte_q;
	logic [19:0]   rep_q;
	logic [2:0]    code_q;

	logic [19:0]   limit;
	logic [9:0]    j10, cnt10;
	logic [21:0]   w0, len0;
	logic [22:0]   add;
	logic [23:0]   newlen;
	logic          pending, append_ok, slot_free;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;

	assign limit     = mzr_pkg::level_limit(level_q);
	assign j10       = {1'b0, sym_q} - 10'd1;
	assign cnt10     = 10'(count_q);
	assign pending   = (weight_q != '0);
	assign w0        = pending ? weight_q : 22'd1;
	assign len0      = pending ? len_q : 22'd0;
	assign add       = sym_q[0] ? {w0, 1'b0} : {1'b0, w0};
	assign newlen    = 24'(len0) + 24'(add);
	assign slot_free = !out_valid_q || out_ready;
	assign append_ok = cmd.accept && (op == mzr_pkg::OP_APPEND) && open_q
		&& (held_q == mzr_pkg::ERR_NONE) && (count_q < CW'(ALPHABET_DEPTH));

	always_comb begin
		stat              = '0;
		stat.held_nz      = (held_q != mzr_pkg::ERR_NONE);
		stat.held_code    = held_q;
		stat.open         = open_q;
		stat.count_zero   = (count_q == '0);
		stat.is_run       = (sym_q[8:1] == '0);
		stat.run_pending  = pending;
		stat.run_over     = newlen > 24'(limit);
		stat.flush_over   = (23'(fill_q) + 23'(len_q)) > 23'(limit);
		stat.is_end       = ({1'b0, sym_q} == cnt10 + 10'd1);
		stat.out_of_range = (j10 >= cnt10);
		stat.lit_over     = (fill_q >= limit);
		stat.idx_zero     = (idx_q == '0);
		stat.slot_free    = slot_free;
	end

	// one write port shared by alphabet load, shift and front write
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata_q;
		if (append_ok) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = in_byte;
		end else if (cmd.shift_wr) begin
			we = 1'b1;
		end else if (cmd.front_wr) begin
			we    = 1'b1;
			waddr = '0;
			wdata = b_q;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			mzr_pkg::RD_J:    raddr = j10[AW-1:0];
			mzr_pkg::RD_PREV: raddr = idx_q - AW'(1);
			default:          raddr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= mzr_pkg::LEVEL_RESET;
			count_q     <= '0;
			weight_q    <= '0;
			len_q       <= '0;
			fill_q      <= '0;
			open_q      <= 1'b0;
			held_q      <= mzr_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				level_q <= cfg_wdata;
			end
			if (cmd.accept && op == mzr_pkg::OP_START) begin
				count_q  <= '0;
				weight_q <= '0;
				len_q    <= '0;
				fill_q   <= '0;
				held_q   <= mzr_pkg::ERR_NONE;
				open_q   <= 1'b1;
			end
			if (append_ok) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.run_upd) begin
				weight_q <= {w0[20:0], 1'b0};
				len_q    <= newlen[21:0];
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				case (cmd.emit_sel)
					mzr_pkg::RES_RUN: begin
						weight_q <= '0;
						len_q    <= '0;
						fill_q   <= fill_q + len_q[19:0];
					end
					mzr_pkg::RES_END: open_q <= 1'b0;
					mzr_pkg::RES_LIT: fill_q <= fill_q + 20'd1;
					default: begin
						held_q <= cmd.emit_code;
						open_q <= 1'b0;
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q <= symbol;
		end
		if (append_ok && count_q == '0) begin
			front_q <= in_byte;
		end
		if (cmd.rd_sel == mzr_pkg::RD_J) begin
			idx_q <= j10[AW-1:0];
		end else if (cmd.shift_wr) begin
			idx_q <= idx_q - AW'(1);
		end
		if (cmd.cap_b) begin
			b_q <= rdata_q;
		end
		if (cmd.front_wr) begin
			front_q <= b_q;
		end
		if (cmd.emit) begin
			last_q <= cmd.emit_last;
			code_q <= mzr_pkg::ERR_NONE;
			byte_q <= '0;
			rep_q  <= '0;
			case (cmd.emit_sel)
				mzr_pkg::RES_RUN: begin
					kind_q <= mzr_pkg::KIND_RUN;
					byte_q <= front_q;
					rep_q  <= len_q[19:0];
				end
				mzr_pkg::RES_END: kind_q <= mzr_pkg::KIND_END;
				mzr_pkg::RES_LIT: begin
					kind_q <= mzr_pkg::KIND_RUN;
					byte_q <= b_q;
					rep_q  <= 20'd1;
				end
				default: begin
					kind_q <= mzr_pkg::KIND_ERR;
					code_q <= cmd.emit_code;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign out_byte   = byte_q;
	assign repeat_res = rep_q;
	assign error_code = code_q;
	assign last       = last_q;

endmodule

FILE: src/mtf_zero_run_decoder_top.sv
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    op, in_byte, symbol
// out       out  out_valid / out_ready  kind, out_byte, repeat_res, error_code, last
// cfg       in   cfg_we                 cfg_wdata (block_level)
//
// start, append and unused ops are taken in idle; a run symbol passes idle and decide
// an error found at decide goes straight to the final emit; an end code or a literal first passes
// the symbol check, after the run emit when a pending run is flushed; a literal at list position j
// reads entry j, then the move-to-front shift walks the list, one read and one write per entry
// reset is asynchronous; the list memory is not cleared, only written entries are read
// a stalled output holds its result; requests are still taken, a decode then waits at its emit

`include "mtf_zero_run_decoder_top_assert.svh"

module mtf_zero_run_decoder_top #(
	parameter int ALPHABET_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  in_byte,
	input  logic [8:0]  symbol,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [19:0] repeat_res,
	output logic [2:0]  error_code,
	output logic        last
);

	// command and status between sequencer and datapath
	mzr_pkg::cmd_t  cmd;
	mzr_pkg::stat_t stat;

	// sequencer: decide, flush, move-to-front walk, emit
	mzr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: counters, run accumulator, list memory, output register
	mzr_datapath #(
		.ALPHABET_DEPTH (ALPHABET_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.op         (op),
		.in_byte    (in_byte),
		.symbol     (symbol),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_byte   (out_byte),
		.repeat_res (repeat_res),
		.error_code (error_code),
		.last       (last)
	);

	// an error result carries a code and no byte payload
	`MZR_ASSERT_IMPLY(a_err_shape, clk, arst_n,
		out_valid && kind == mzr_pkg::KIND_ERR,
		error_code != mzr_pkg::ERR_NONE && out_byte == 8'd0 && repeat_res == 20'd0)
	// a byte run is never empty
	`MZR_ASSERT_IMPLY(a_run_nonzero, clk, arst_n,
		out_valid && kind == mzr_pkg::KIND_RUN, repeat_res != 20'd0)
	// a decode request always keeps the sequencer busy next cycle
	`MZR_ASSERT_NEXT(a_decode_busy, clk, arst_n,
		in_valid && in_ready && op == mzr_pkg::OP_DECODE, !in_ready)

endmodule

FILE: test/mtf_zero_run_decoder_top_tb.sv
module mtf_zero_run_decoder_top_tb;

	// op code that the block ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// symbols with a fixed meaning
	localparam logic [8:0] SYM_RUNA = 9'd0;
	localparam logic [8:0] SYM_RUNB = 9'd1;
	// settle time before a register write, covers a full-list shift
	localparam int SETTLE_CYCLES = 700;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int RANDOM_ITEMS = 500;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [19:0] repeat_res;
		logic [2:0]  error_code;
		logic        last;
	} mzr_result_t;

	// predicts the decoder results and checks them in order
	class mtf_scoreboard;
		logic [7:0]  mtf_bytes [256];
		int unsigned alpha_cnt;
		int unsigned run_wt;
		int unsigned run_len;
		int unsigned fill;
		bit          blk_open;
		logic [2:0]  held_code;
		logic [3:0]  level;
		mzr_result_t pending_q [$];
		int          errors;

		function new();
			alpha_cnt = 0;
			run_wt = 0;
			run_len = 0;
			fill = 0;
			blk_open = 0;
			held_code = mzr_pkg::ERR_NONE;
			level = mzr_pkg::LEVEL_RESET;
			errors = 0;
		endfunction

		function void add(logic [1:0] k, logic [7:0] b, logic [19:0] r, logic [2:0] c);
			mzr_result_t e;
			e.kind = k;
			e.out_byte = b;
			e.repeat_res = r;
			e.error_code = c;
			e.last = 1'b0;
			pending_q.insert(pending_q.size(), e);
		endfunction

		function void raise_error(logic [2:0] c);
			held_code = c;
			blk_open = 0;
			add(mzr_pkg::KIND_ERR, 8'd0, 20'd0, c);
		endfunction

		function int unsigned block_cap();
			int unsigned lv;
			lv = level;
			if (lv < 1) lv = 1;
			if (lv > 9) lv = 9;
			return lv * mzr_pkg::BLOCK_UNIT;
		endfunction

		function void decode_symbol(logic [8:0] s);
			int unsigned cap;
			int unsigned j;
			logic [7:0] b;
			cap = block_cap();
			if (held_code != mzr_pkg::ERR_NONE) begin
				add(mzr_pkg::KIND_ERR, 8'd0, 20'd0, held_code);
				return;
			end
			if (!blk_open) begin
				raise_error(mzr_pkg::ERR_NO_BLOCK);
				return;
			end
			if (alpha_cnt == 0) begin
				raise_error(mzr_pkg::ERR_RANGE);
				return;
			end
			// run digits, bijective base 2
			if (s <= SYM_RUNB) begin
				if (run_wt == 0) begin
					run_wt = 1;
					run_len = 0;
				end
				run_len += run_wt << s;
				run_wt <<= 1;
				if (run_len > cap) raise_error(mzr_pkg::ERR_RUN_OVF);
				return;
			end
			// flush a pending run first
			if (run_wt != 0) begin
				run_wt = 0;
				if (fill + run_len > cap) begin
					raise_error(mzr_pkg::ERR_BLK_OVF);
					return;
				end
				add(mzr_pkg::KIND_RUN, mtf_bytes[0], 20'(run_len), mzr_pkg::ERR_NONE);
				fill += run_len;
				run_len = 0;
			end
			if (s == alpha_cnt + 1) begin
				blk_open = 0;
				add(mzr_pkg::KIND_END, 8'd0, 20'd0, mzr_pkg::ERR_NONE);
				return;
			end
			j = s - 1;
			if (j >= alpha_cnt) begin
				raise_error(mzr_pkg::ERR_RANGE);
				return;
			end
			b = mtf_bytes[j];
			for (int i = j; i > 0; i--) mtf_bytes[i] = mtf_bytes[i-1];
			mtf_bytes[0] = b;
			if (fill >= cap) begin
				raise_error(mzr_pkg::ERR_BLK_OVF);
				return;
			end
			fill++;
			add(mzr_pkg::KIND_RUN, b, 20'd1, mzr_pkg::ERR_NONE);
		endfunction

		// called for every accepted request
		function void note_request(logic [1:0] o, logic [7:0] b, logic [8:0] s);
			int n0;
			n0 = pending_q.size();
			case (o)
				mzr_pkg::OP_START: begin
					alpha_cnt = 0;
					run_wt = 0;
					run_len = 0;
					fill = 0;
					held_code = mzr_pkg::ERR_NONE;
					blk_open = 1;
				end
				mzr_pkg::OP_APPEND: begin
					if (blk_open && held_code == mzr_pkg::ERR_NONE && alpha_cnt < 256) begin
						mtf_bytes[alpha_cnt] = b;
						alpha_cnt++;
					end
				end
				mzr_pkg::OP_DECODE: decode_symbol(s);
				default: ;
			endcase
			if (pending_q.size() > n0) pending_q[pending_q.size()-1].last = 1'b1;
		endfunction

		function void check_result(logic [1:0] k, logic [7:0] b, logic [19:0] r,
				logic [2:0] c, logic l);
			mzr_result_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result kind=%0d byte=%0d repeat=%0d code=%0d last=%0d",
					k, b, r, c, l);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (k !== e.kind) begin
				$error("kind: expected %0d actual %0d", e.kind, k);
				errors++;
			end
			if (b !== e.out_byte) begin
				$error("out_byte: expected %0d actual %0d", e.out_byte, b);
				errors++;
			end
			if (r !== e.repeat_res) begin
				$error("repeat_res: expected %0d actual %0d", e.repeat_res, r);
				errors++;
			end
			if (c !== e.error_code) begin
				$error("error_code: expected %0d actual %0d", e.error_code, c);
				errors++;
			end
			if (l !== e.last) begin
				$error("last: expected %0d actual %0d", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  in_byte;
	logic [8:0]  symbol;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [19:0] repeat_res;
	logic [2:0]  error_code;
	logic        last;

	mtf_scoreboard sb;
	bit no_gaps;      // long stretch with both sides always busy
	int n_items;
	int cycles;

	mtf_zero_run_decoder_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.in_byte    (in_byte),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_byte   (out_byte),
		.repeat_res (repeat_res),
		.error_code (error_code),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog on total run length
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL mtf_zero_run_decoder_top");
			$finish;
		end
	end

	// receiver: random back-pressure, changed on the falling edge
	always @(negedge clk) begin
		if (!arst_n || no_gaps) out_ready = 1'b1;
		else out_ready = ($urandom_range(99) >= 27);
	end

	// every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(kind, out_byte, repeat_res, error_code, last);
	end

	// one request, with random gaps in front of it
	task automatic push_item(input logic [1:0] o, input logic [7:0] b, input logic [8:0] s);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 27) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		in_byte = b;
		symbol = s;
		do @(posedge clk); while (!in_ready);
		sb.note_request(o, b, s);
		n_items++;
	endtask

	task automatic decode_sym(input logic [8:0] s);
		push_item(mzr_pkg::OP_DECODE, 8'($urandom), s);
	endtask

	task automatic append_byte(input logic [7:0] b);
		push_item(mzr_pkg::OP_APPEND, b, 9'($urandom));
	endtask

	task automatic start_block();
		push_item(mzr_pkg::OP_START, 8'($urandom), 9'($urandom));
	endtask

	// run of n copies as bijective base-2 digits, least significant first
	task automatic send_run(input int unsigned n);
		while (n > 0) begin
			if (n[0]) begin
				decode_sym(SYM_RUNA);
				n = (n - 1) / 2;
			end else begin
				decode_sym(SYM_RUNB);
				n = (n - 2) / 2;
			end
		end
	endtask

	// lower valid and wait until no result is outstanding
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
	endtask

	// register write only with the block idle
	task automatic set_level(input logic [3:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.level = v;
	endtask

	// one random block: ascending alphabet, then mostly well-formed symbols
	task automatic random_block();
		bit pick [256];
		int n;
		int picked;
		int k;
		int r;
		n = ($urandom_range(99) < 6) ? 256 :
			($urandom_range(99) < 4) ? 0 : $urandom_range(1, 8);
		for (int i = 0; i < 256; i++) pick[i] = (n == 256);
		picked = (n == 256) ? 256 : 0;
		while (picked < n) begin
			r = $urandom_range(0, 255);
			if (!pick[r]) begin
				pick[r] = 1;
				picked++;
			end
		end
		start_block();
		for (int i = 0; i < 256; i++) if (pick[i]) append_byte(8'(i));
		k = $urandom_range(4, 24);
		for (int i = 0; i < k; i++) begin
			r = $urandom_range(99);
			if (r < 30) decode_sym(9'($urandom_range(0, 1)));
			else if (r < 32) send_run($urandom_range(1000, 200000));
			else if (r < 80) begin
				if (n >= 2) begin
					// big list: mostly near the front, sometimes anywhere
					if (n > 16 && $urandom_range(9) != 0) decode_sym(9'($urandom_range(2, 12)));
					else decode_sym(9'($urandom_range(2, n)));
				end else decode_sym(SYM_RUNA);
			end
			else if (r < 84) push_item(OP_UNUSED, 8'($urandom), 9'($urandom));
			else if (r < 87) append_byte(8'($urandom));
			else if (r < 91) decode_sym(9'($urandom_range(0, 511)));
		end
		if ($urandom_range(99) < 80) decode_sym(9'(n + 1));
		if ($urandom_range(99) < 10) decode_sym(9'($urandom_range(0, 511)));
	endtask

	initial begin
		int blocks;
		sb = new();
		no_gaps = 0;
		n_items = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = mzr_pkg::LEVEL_RESET;
		in_valid = 1'b0;
		op = mzr_pkg::OP_START;
		in_byte = 8'd0;
		symbol = 9'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: error paths and basic decoding at the smallest level
		set_level(4'd1);
		decode_sym(9'd2);             // no open block
		decode_sym(9'd3);             // held error repeats
		push_item(OP_UNUSED, 8'hff, 9'h1ff);
		start_block();
		decode_sym(9'd2);             // empty alphabet
		start_block();
		append_byte(8'h00);
		append_byte(8'haa);
		append_byte(8'hff);
		decode_sym(SYM_RUNA);
		decode_sym(SYM_RUNB);
		decode_sym(9'd3);             // flush run, then literal
		decode_sym(9'd2);
		decode_sym(9'd4);             // end code
		decode_sym(9'd2);             // after end
		start_block();
		append_byte(8'h10);
		append_byte(8'h20);
		decode_sym(SYM_RUNA);
		decode_sym(9'd257);           // above end: flush then range error
		decode_sym(9'd2);             // held range error
		append_byte(8'h30);           // ignored while errored

		// overflow cases, level 0 acts as level 1
		set_level(4'd0);
		start_block();
		append_byte(8'h01);
		append_byte(8'h02);
		send_run(100001);             // run overflow
		start_block();
		append_byte(8'h01);
		append_byte(8'h02);
		send_run(100000);
		decode_sym(9'd2);             // block full: flush, literal overflows
		start_block();
		append_byte(8'h05);
		append_byte(8'h06);
		send_run(60000);
		decode_sym(9'd3);
		send_run(50000);
		decode_sym(9'd3);             // flushed run overflows the block

		// random phases over several levels
		set_level(4'd15);
		blocks = 0;
		while (n_items < RANDOM_ITEMS || blocks < 10) begin
			if (blocks == 2) set_level(4'd9);
			if (blocks == 4) set_level(4'($urandom_range(1, 8)));
			if (blocks == 8) set_level(4'd1);
			if (blocks == 3) drain();  // sender waits for all results
			no_gaps = (blocks >= 5 && blocks < 8);
			random_block();
			blocks++;
		end
		no_gaps = 0;

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("PASS mtf_zero_run_decoder_top");
		end else begin
			$display("FAIL mtf_zero_run_decoder_top");
		end
		$finish;
	end

endmodule
